// File: hw/rtl/ddpb_pkg.sv
// Shared types, constants and the dot depletion function for the
// depletion and PackBits line encoder. No dependencies.
package ddpb_pkg;

    localparam int MAX_LINE_BYTES_DEFAULT = 4096;
    localparam int MAX_SEGMENT_DEFAULT    = 127;

    localparam int ADDR_W     = 13;
    localparam int BYTE_W     = 8;
    localparam int MAX_WRITES = 4;     // worst case writes caused by one byte
    localparam int SLOT_W     = $clog2(MAX_WRITES);
    localparam int WCNT_W     = $clog2(MAX_WRITES + 1);
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPLETE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESS_MODE  = 2'd1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {
        SEG_NONE = 2'd0,
        SEG_RUN  = 2'd1,
        SEG_LIT  = 2'd2
    } seg_kind_t;

    typedef struct packed {
        logic deplete_enable;
        logic compress_mode;
    } cfg_t;

    // All writes caused by one raster byte
    typedef struct packed {
        logic [MAX_WRITES-1:0][ADDR_W-1:0] addr;
        logic [MAX_WRITES-1:0][BYTE_W-1:0] value;
        logic [WCNT_W-1:0]                 count;
        logic                              line_done;
    } bundle_t;

    typedef struct packed {
        logic empty;
        logic full;
    } queue_status_t;

    // Clear any dot whose left neighbour survives, scanning from the MSB
    function automatic byte_t deplete(input byte_t b, input logic carry);
        byte_t r;
        logic  prev;
        prev = carry;
        for (int i = BYTE_W - 1; i >= 0; i--)
        begin
            r[i] = b[i] & ~prev;
            prev = r[i];
        end
        return r;
    endfunction

endpackage

// File: hw/rtl/ddpb_if.sv
// Channel interfaces of the encoder: raster input, buffer writes, config.
// Depends on ddpb_pkg.
interface ddpb_in_if;
    logic                 valid;
    logic                 ready;
    logic [ddpb_pkg::BYTE_W-1:0] data_byte;
    logic                 line_last;

    modport source (output valid, data_byte, line_last, input ready);
    modport sink   (input valid, data_byte, line_last, output ready);
endinterface

interface ddpb_out_if;
    logic                 valid;
    logic                 ready;
    logic [ddpb_pkg::ADDR_W-1:0] write_address;
    logic [ddpb_pkg::BYTE_W-1:0] write_value;
    logic                 line_done;

    modport source (output valid, write_address, write_value, line_done, input ready);
    modport sink   (input valid, write_address, write_value, line_done, output ready);
endinterface

interface ddpb_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ddpb_pkg::CFG_IDX_W-1:0]  index;
    logic [ddpb_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/ddpb_front.sv
// Front end: accepts raster bytes, applies optional depletion and PackBits
// segmentation, and pushes a bundle for each byte with writes. Uses ddpb_pkg.
module ddpb_front #(
    parameter int MAX_LINE_BYTES = ddpb_pkg::MAX_LINE_BYTES_DEFAULT,
    parameter int MAX_SEGMENT    = ddpb_pkg::MAX_SEGMENT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ddpb_pkg::cfg_t    cfg,
    ddpb_in_if.sink           raster,
    input  ddpb_pkg::queue_status_t q_status,
    output logic              push_valid,
    output ddpb_pkg::bundle_t push_bundle
);

    localparam int POS_W = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int CNT_W = $clog2(MAX_SEGMENT + 1);
    localparam logic [POS_W:0]   LAST_POS = (POS_W + 1)'(MAX_LINE_BYTES);
    localparam logic [CNT_W-1:0] SEG_MAX  = CNT_W'(MAX_SEGMENT);
    localparam logic [CNT_W-1:0] RUN_START = CNT_W'(2);

    ddpb_pkg::byte_t     pending_byte_reg, pending_byte_next;
    logic                pending_valid_reg, pending_valid_next;
    logic                dot_carry_reg, dot_carry_next;
    ddpb_pkg::seg_kind_t seg_kind_reg, seg_kind_next;
    logic [CNT_W-1:0]    seg_count_reg, seg_count_next;
    ddpb_pkg::addr_t     header_addr_reg, header_addr_next;
    ddpb_pkg::addr_t     next_addr_reg, next_addr_next;
    logic [POS_W-1:0]    line_pos_reg, line_pos_next;
    logic                line_mode_reg, line_mode_next;

    logic                accept;
    logic                last_eff;
    logic                mode_eff;
    ddpb_pkg::byte_t     byte_x;
    logic [ddpb_pkg::WCNT_W-1:0] n;
    ddpb_pkg::bundle_t   bundle;

    assign raster.ready = !q_status.full;
    assign accept       = raster.valid && raster.ready;
    assign push_valid   = accept && (n != '0);
    assign push_bundle  = bundle;

    always_comb
    begin
        pending_byte_next  = pending_byte_reg;
        pending_valid_next = pending_valid_reg;
        seg_kind_next      = seg_kind_reg;
        seg_count_next     = seg_count_reg;
        header_addr_next   = header_addr_reg;
        next_addr_next     = next_addr_reg;
        bundle             = '0;
        n                  = '0;

        last_eff = raster.line_last || (({1'b0, line_pos_reg} + 1'b1) >= LAST_POS);
        mode_eff = (line_pos_reg == '0) ? cfg.compress_mode : line_mode_reg;
        byte_x   = cfg.deplete_enable ? ddpb_pkg::deplete(raster.data_byte, dot_carry_reg)
                                      : raster.data_byte;

        if (!mode_eff)
        begin
            bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
            bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = byte_x;
            n = n + 1'b1;
            next_addr_next = next_addr_next + 1'b1;
        end
        else
        begin
            unique case (seg_kind_reg)
                ddpb_pkg::SEG_RUN:
                begin
                    if (pending_byte_reg == byte_x)
                    begin
                        seg_count_next = seg_count_next + 1'b1;
                        if (seg_count_next >= SEG_MAX)
                        begin
                            bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                            bundle.value[n[ddpb_pkg::SLOT_W-1:0]] =
                                8'(9'd257 - 9'(seg_count_next));
                            n = n + 1'b1;
                            next_addr_next = next_addr_next + 1'b1;
                            bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                            bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = byte_x;
                            n = n + 1'b1;
                            next_addr_next = next_addr_next + 1'b1;
                            seg_kind_next      = ddpb_pkg::SEG_NONE;
                            seg_count_next     = '0;
                            pending_valid_next = 1'b0;
                        end
                    end
                    else
                    begin
                        bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                        bundle.value[n[ddpb_pkg::SLOT_W-1:0]] =
                            8'(9'd257 - 9'(seg_count_next));
                        n = n + 1'b1;
                        next_addr_next = next_addr_next + 1'b1;
                        bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                        bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = pending_byte_reg;
                        n = n + 1'b1;
                        next_addr_next = next_addr_next + 1'b1;
                        seg_kind_next     = ddpb_pkg::SEG_NONE;
                        seg_count_next    = '0;
                        pending_byte_next = byte_x;
                    end
                end
                ddpb_pkg::SEG_LIT:
                begin
                    if (pending_byte_reg != byte_x)
                    begin
                        bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                        bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = pending_byte_reg;
                        n = n + 1'b1;
                        next_addr_next    = next_addr_next + 1'b1;
                        seg_count_next    = seg_count_next + 1'b1;
                        pending_byte_next = byte_x;
                        if (seg_count_next >= SEG_MAX)
                        begin
                            bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = header_addr_next;
                            bundle.value[n[ddpb_pkg::SLOT_W-1:0]] =
                                8'(seg_count_next - 1'b1);
                            n = n + 1'b1;
                            seg_kind_next  = ddpb_pkg::SEG_NONE;
                            seg_count_next = '0;
                        end
                    end
                    else
                    begin
                        // close literal, then the repeated byte opens a run
                        bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = header_addr_next;
                        bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = 8'(seg_count_next - 1'b1);
                        n = n + 1'b1;
                        pending_byte_next  = byte_x;
                        pending_valid_next = 1'b1;
                        seg_kind_next      = ddpb_pkg::SEG_RUN;
                        seg_count_next     = RUN_START;
                        if (seg_count_next >= SEG_MAX)
                        begin
                            bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                            bundle.value[n[ddpb_pkg::SLOT_W-1:0]] =
                                8'(9'd257 - 9'(seg_count_next));
                            n = n + 1'b1;
                            next_addr_next = next_addr_next + 1'b1;
                            bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                            bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = byte_x;
                            n = n + 1'b1;
                            next_addr_next = next_addr_next + 1'b1;
                            seg_kind_next      = ddpb_pkg::SEG_NONE;
                            seg_count_next     = '0;
                            pending_valid_next = 1'b0;
                        end
                    end
                end
                default:
                begin
                    if (pending_valid_reg)
                    begin
                        pending_byte_next = byte_x;
                        if (pending_byte_reg == byte_x)
                        begin
                            seg_kind_next  = ddpb_pkg::SEG_RUN;
                            seg_count_next = RUN_START;
                            if (seg_count_next >= SEG_MAX)
                            begin
                                bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                                bundle.value[n[ddpb_pkg::SLOT_W-1:0]] =
                                    8'(9'd257 - 9'(seg_count_next));
                                n = n + 1'b1;
                                next_addr_next = next_addr_next + 1'b1;
                                bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                                bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = byte_x;
                                n = n + 1'b1;
                                next_addr_next = next_addr_next + 1'b1;
                                seg_kind_next      = ddpb_pkg::SEG_NONE;
                                seg_count_next     = '0;
                                pending_valid_next = 1'b0;
                            end
                        end
                        else
                        begin
                            // reserve the control slot, then store the first byte
                            seg_kind_next    = ddpb_pkg::SEG_LIT;
                            header_addr_next = next_addr_next;
                            next_addr_next   = next_addr_next + 1'b1;
                            bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                            bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = pending_byte_reg;
                            n = n + 1'b1;
                            next_addr_next = next_addr_next + 1'b1;
                            seg_count_next = CNT_W'(1);
                        end
                    end
                    else
                    begin
                        pending_byte_next  = byte_x;
                        pending_valid_next = 1'b1;
                    end
                end
            endcase

            if (last_eff)
            begin
                if (seg_kind_next == ddpb_pkg::SEG_RUN)
                begin
                    bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                    bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = 8'(9'd257 - 9'(seg_count_next));
                    n = n + 1'b1;
                    next_addr_next = next_addr_next + 1'b1;
                    bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                    bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = pending_byte_next;
                    n = n + 1'b1;
                    next_addr_next = next_addr_next + 1'b1;
                end
                else
                begin
                    if (seg_kind_next == ddpb_pkg::SEG_LIT)
                    begin
                        bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = header_addr_next;
                        bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = 8'(seg_count_next - 1'b1);
                        n = n + 1'b1;
                    end
                    if (pending_valid_next)
                    begin
                        // lone trailing byte: its own one-byte literal
                        bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                        bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = '0;
                        n = n + 1'b1;
                        next_addr_next = next_addr_next + 1'b1;
                        bundle.addr[n[ddpb_pkg::SLOT_W-1:0]]  = next_addr_next;
                        bundle.value[n[ddpb_pkg::SLOT_W-1:0]] = pending_byte_next;
                        n = n + 1'b1;
                        next_addr_next = next_addr_next + 1'b1;
                    end
                end
            end
        end

        bundle.count     = n;
        bundle.line_done = last_eff;

        line_mode_next = mode_eff;
        if (last_eff)
        begin
            pending_byte_next  = '0;
            pending_valid_next = 1'b0;
            dot_carry_next     = 1'b0;
            seg_kind_next      = ddpb_pkg::SEG_NONE;
            seg_count_next     = '0;
            next_addr_next     = '0;
            line_pos_next      = '0;
        end
        else
        begin
            dot_carry_next = byte_x[0];
            line_pos_next  = line_pos_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_byte_reg  <= '0;
            pending_valid_reg <= 1'b0;
            dot_carry_reg     <= 1'b0;
            seg_kind_reg      <= ddpb_pkg::SEG_NONE;
            seg_count_reg     <= '0;
            header_addr_reg   <= '0;
            next_addr_reg     <= '0;
            line_pos_reg      <= '0;
            line_mode_reg     <= 1'b0;
        end
        else if (accept)
        begin
            pending_byte_reg  <= pending_byte_next;
            pending_valid_reg <= pending_valid_next;
            dot_carry_reg     <= dot_carry_next;
            seg_kind_reg      <= seg_kind_next;
            seg_count_reg     <= seg_count_next;
            header_addr_reg   <= header_addr_next;
            next_addr_reg     <= next_addr_next;
            line_pos_reg      <= line_pos_next;
            line_mode_reg     <= line_mode_next;
        end
    end

endmodule

// File: hw/rtl/ddpb_queue.sv
// Short bundle queue between front and back ends.
// Uses ddpb_pkg.
module ddpb_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push_valid,
    input  ddpb_pkg::bundle_t       push_bundle,
    input  logic                    pop,
    output ddpb_pkg::bundle_t       head,
    output ddpb_pkg::queue_status_t status
);

    ddpb_pkg::bundle_t entries_reg [ddpb_pkg::QUEUE_DEPTH];
    logic [ddpb_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ddpb_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ddpb_pkg::QCNT_W-1:0] count_reg, count_next;
    logic do_push;
    logic do_pop;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == ddpb_pkg::QCNT_W'(ddpb_pkg::QUEUE_DEPTH));
    assign do_push      = push_valid && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_bundle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: hw/rtl/ddpb_back.sv
// Back end: walks each queued bundle one write at a time into the
// output register. Uses ddpb_pkg and ddpb_out_if.
module ddpb_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ddpb_pkg::bundle_t       head,
    input  ddpb_pkg::queue_status_t q_status,
    output logic                    pop,
    ddpb_out_if.source              writes
);

    logic [ddpb_pkg::SLOT_W-1:0] slot_reg, slot_next;
    logic                        out_valid_reg, out_valid_next;
    ddpb_pkg::addr_t             out_addr_reg;
    ddpb_pkg::byte_t             out_value_reg;
    logic                        out_done_reg;
    logic                        load;
    logic                        last_slot;

    assign load      = !q_status.empty && (!out_valid_reg || writes.ready);
    assign last_slot = (ddpb_pkg::WCNT_W'(slot_reg) + 1'b1) == head.count;
    assign pop       = load && last_slot;

    assign writes.valid         = out_valid_reg;
    assign writes.write_address = out_addr_reg;
    assign writes.write_value   = out_value_reg;
    assign writes.line_done     = out_done_reg;

    always_comb
    begin
        slot_next      = slot_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            slot_next      = last_slot ? '0 : slot_reg + 1'b1;
        end
        else if (writes.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_addr_reg  <= head.addr[slot_reg];
            out_value_reg <= head.value[slot_reg];
            out_done_reg  <= head.line_done && last_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: hw/rtl/dot_depletion_packbits_encoder.sv
// Top level of the dot depletion and PackBits line encoder.
// Uses ddpb_pkg, ddpb_if, ddpb_front, ddpb_queue and ddpb_back.
//
// The encoder takes one raster byte per clock on the raster channel and
// turns each line into addressed writes for the line's output buffer:
// either the bytes unchanged or PackBits coded, after optional clearing of
// horizontally adjacent dots. A byte causes zero to four writes. The front
// end accepts a byte every cycle while its four-entry bundle queue has room;
// it works out all writes of a byte in that cycle. The back end presents
// one write per cycle from the bundle queue through its output register
// while the output is ready, so the encoder keeps pace with the raster
// bytes whenever the output averages no more than one write per byte (runs
// need far fewer writes, a line end needs up to four). Literal control
// bytes arrive at their reserved address once the literal closes, so the
// buffer is not written in address order. compress_mode is taken at the
// first byte of each line; deplete_enable applies from the next byte.
// Configuration is written by index: 0 deplete_enable, 1 compress_mode,
// bit 0 of the data; other indexes are ignored.
module dot_depletion_packbits_encoder #(
    parameter int MAX_LINE_BYTES = ddpb_pkg::MAX_LINE_BYTES_DEFAULT,
    parameter int MAX_SEGMENT    = ddpb_pkg::MAX_SEGMENT_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    ddpb_cfg_if.sink   cfg,
    ddpb_in_if.sink    raster,
    ddpb_out_if.source writes
);

    // configuration registers
    logic deplete_enable_reg, deplete_enable_next;
    logic compress_mode_reg, compress_mode_next;

    ddpb_pkg::cfg_t          cfg_now;
    ddpb_pkg::queue_status_t q_status;
    ddpb_pkg::bundle_t       push_bundle;
    ddpb_pkg::bundle_t       head;
    logic                    push_valid;
    logic                    pop;

    // writes are always taken
    assign cfg.ready = 1'b1;

    always_comb
    begin
        deplete_enable_next = deplete_enable_reg;
        compress_mode_next  = compress_mode_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                ddpb_pkg::CFG_DEPLETE_ENABLE: deplete_enable_next = cfg.data[0];
                ddpb_pkg::CFG_COMPRESS_MODE:  compress_mode_next  = cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deplete_enable_reg <= 1'b0;
            compress_mode_reg  <= 1'b1;
        end
        else
        begin
            deplete_enable_reg <= deplete_enable_next;
            compress_mode_reg  <= compress_mode_next;
        end
    end

    assign cfg_now.deplete_enable = deplete_enable_reg;
    assign cfg_now.compress_mode  = compress_mode_reg;

    // front end: depletion, segmentation, write generation
    ddpb_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .MAX_SEGMENT    (MAX_SEGMENT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_now),
        .raster      (raster),
        .q_status    (q_status),
        .push_valid  (push_valid),
        .push_bundle (push_bundle)
    );

    // decouples the byte stream from the write stream
    ddpb_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_valid  (push_valid),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head        (head),
        .status      (q_status)
    );

    // back end: one write per transaction on the output channel
    ddpb_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .writes   (writes)
    );

endmodule
